// ----- hw/rtl/assert_macros.svh -----
// assertion macros for the collision contact rtl, used by ccc_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is held
`define CCC_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds across reset
`define CCC_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/ccc_pkg.sv -----
// shared types and defaults for the collision contact pipeline
package ccc_pkg;

    localparam int CCC_COORD_WIDTH      = 24;
    localparam int CCC_NORMAL_FRAC_BITS = 14;

    // per-word flags that travel with the data down the pipeline
    typedef struct packed {
        logic box;
        logic hit;
        logic sdx;
        logic sdy;
    } t_flags;

endpackage

// ----- hw/rtl/ccc_front.sv -----
// front stages: closest point, offsets, squares and hit compare
module ccc_front import ccc_pkg::*; #(
    parameter int W = CCC_COORD_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_req_type,
    input  logic signed [W-1:0] i_center_x,
    input  logic signed [W-1:0] i_center_y,
    input  logic        [W-2:0] i_circle_radius,
    input  logic signed [W-1:0] i_other_x,
    input  logic signed [W-1:0] i_other_y,
    input  logic        [W-2:0] i_other_radius,
    input  logic        [W-2:0] i_box_width,
    input  logic        [W-2:0] i_box_height,
    output logic                o_valid,
    output t_flags              o_flags,
    output logic      [2*W+1:0] o_dsq,
    output logic          [W:0] o_magdx,
    output logic          [W:0] o_magdy,
    output logic        [W-1:0] o_reach,
    output logic        [W-2:0] o_r,
    output logic        [W-1:0] o_cx,
    output logic        [W-1:0] o_cy,
    output logic        [W-1:0] o_px,
    output logic        [W-1:0] o_py
);

    // stage 1: extended coordinates, box far edges, reach
    logic              r1_valid, r1_box;
    logic signed [W:0] r1_cxe, r1_cye, r1_oxe, r1_oye, r1_hxe, r1_hye;
    logic    [W-2:0]   r1_r;
    logic    [W-1:0]   r1_reach;
    logic signed [W:0] n1_hxe, n1_hye;
    logic    [W-1:0]   n1_reach;

    always_comb begin
        n1_hxe   = $signed({i_other_x[W-1], i_other_x}) + $signed({2'b00, i_box_width});
        n1_hye   = $signed({i_other_y[W-1], i_other_y}) + $signed({2'b00, i_box_height});
        n1_reach = i_req_type ? {1'b0, i_circle_radius}
                              : {1'b0, i_circle_radius} + {1'b0, i_other_radius};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
        end
        r1_box   <= i_req_type;
        r1_cxe   <= {i_center_x[W-1], i_center_x};
        r1_cye   <= {i_center_y[W-1], i_center_y};
        r1_oxe   <= {i_other_x[W-1], i_other_x};
        r1_oye   <= {i_other_y[W-1], i_other_y};
        r1_hxe   <= n1_hxe;
        r1_hye   <= n1_hye;
        r1_r     <= i_circle_radius;
        r1_reach <= n1_reach;
    end

    // stage 2: clamp to the box and take the offsets
    logic              r2_valid, r2_box;
    logic signed [W:0] r2_dx, r2_dy;
    logic    [W-1:0]   r2_cx, r2_cy, r2_px, r2_py, r2_reach;
    logic    [W-2:0]   r2_r;
    logic signed [W:0] n2_tx, n2_ty;

    always_comb begin
        n2_tx = r1_oxe;
        n2_ty = r1_oye;
        if (r1_box) begin
            if (r1_cxe < r1_oxe) begin
                n2_tx = r1_oxe;
            end else if (r1_cxe > r1_hxe) begin
                n2_tx = r1_hxe;
            end else begin
                n2_tx = r1_cxe;
            end
            if (r1_cye < r1_oye) begin
                n2_ty = r1_oye;
            end else if (r1_cye > r1_hye) begin
                n2_ty = r1_hye;
            end else begin
                n2_ty = r1_cye;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
        r2_box   <= r1_box;
        r2_dx    <= r1_cxe - n2_tx;
        r2_dy    <= r1_cye - n2_ty;
        r2_cx    <= r1_cxe[W-1:0];
        r2_cy    <= r1_cye[W-1:0];
        r2_px    <= n2_tx[W-1:0];
        r2_py    <= n2_ty[W-1:0];
        r2_reach <= r1_reach;
        r2_r     <= r1_r;
    end

    // stage 3: magnitudes and squares
    logic             r3_valid, r3_box, r3_sdx, r3_sdy;
    logic [W:0]       r3_magdx, r3_magdy;
    logic [2*W+1:0]   r3_sqx, r3_sqy;
    logic [2*W-1:0]   r3_rsq;
    logic [W-1:0]     r3_cx, r3_cy, r3_px, r3_py, r3_reach;
    logic [W-2:0]     r3_r;
    logic [W:0]       n3_magdx, n3_magdy;
    logic [2*W+1:0]   n3_sqx, n3_sqy;
    logic [2*W-1:0]   n3_rsq;

    always_comb begin
        n3_magdx = r2_dx[W] ? -r2_dx : r2_dx;
        n3_magdy = r2_dy[W] ? -r2_dy : r2_dy;
        n3_sqx   = n3_magdx * n3_magdx;
        n3_sqy   = n3_magdy * n3_magdy;
        n3_rsq   = r2_reach * r2_reach;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
        r3_box   <= r2_box;
        r3_sdx   <= r2_dx[W];
        r3_sdy   <= r2_dy[W];
        r3_magdx <= n3_magdx;
        r3_magdy <= n3_magdy;
        r3_sqx   <= n3_sqx;
        r3_sqy   <= n3_sqy;
        r3_rsq   <= n3_rsq;
        r3_cx    <= r2_cx;
        r3_cy    <= r2_cy;
        r3_px    <= r2_px;
        r3_py    <= r2_py;
        r3_reach <= r2_reach;
        r3_r     <= r2_r;
    end

    // stage 4: squared distance and strict compare
    logic [2*W+1:0] n4_dsq;

    always_comb begin
        n4_dsq = r3_sqx + r3_sqy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r3_valid;
        end
        o_flags.box <= r3_box;
        o_flags.hit <= n4_dsq < {2'b00, r3_rsq};
        o_flags.sdx <= r3_sdx;
        o_flags.sdy <= r3_sdy;
        o_dsq       <= n4_dsq;
        o_magdx     <= r3_magdx;
        o_magdy     <= r3_magdy;
        o_reach     <= r3_reach;
        o_r         <= r3_r;
        o_cx        <= r3_cx;
        o_cy        <= r3_cy;
        o_px        <= r3_px;
        o_py        <= r3_py;
    end

endmodule

// ----- hw/rtl/ccc_sqrt.sv -----
// pipelined integer square root, one root bit per stage
module ccc_sqrt import ccc_pkg::*; #(
    parameter int N      = CCC_COORD_WIDTH + 1,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [2*N-1:0]    i_rad,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [N-1:0]      o_root,
    output logic [SIDE_W-1:0] o_side
);

    logic [N+1:0]      w_rem  [N];
    logic [N-1:0]      w_root [N];
    logic [2*N-1:0]    w_rad  [N];
    logic [SIDE_W-1:0] w_side [N];
    logic              w_valid[N];

    logic [N+1:0]      r_rem  [N-1];
    logic [2*N-1:0]    r_rad  [N-1];
    logic [N-1:0]      r_root [N];
    logic [SIDE_W-1:0] r_side [N];
    logic              r_valid[N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam int P = 2 * (N - 1 - k);
        logic [N+2:0] cur, trial, diff;
        logic [N+1:0] n_rem;
        logic [N-1:0] n_root;

        // stage inputs
        if (k == 0) begin : g_first
            assign w_rem[k]   = '0;
            assign w_root[k]  = '0;
            assign w_rad[k]   = i_rad;
            assign w_side[k]  = i_side;
            assign w_valid[k] = i_valid;
        end else begin : g_next
            assign w_rem[k]   = r_rem[k-1];
            assign w_root[k]  = r_root[k-1];
            assign w_rad[k]   = r_rad[k-1];
            assign w_side[k]  = r_side[k-1];
            assign w_valid[k] = r_valid[k-1];
        end

        // bring in two radicand bits and try the next root bit
        always_comb begin
            cur   = {w_rem[k][N:0], w_rad[k][P+1:P]};
            trial = {1'b0, w_root[k], 2'b01};
            diff  = cur - trial;
            if (cur >= trial) begin
                n_rem  = diff[N+1:0];
                n_root = {w_root[k][N-2:0], 1'b1};
            end else begin
                n_rem  = cur[N+1:0];
                n_root = {w_root[k][N-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else begin
                r_valid[k] <= w_valid[k];
            end
            r_root[k] <= n_root;
            r_side[k] <= w_side[k];
        end

        // remainder and radicand are not needed past the last stage
        if (k < N - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                r_rem[k] <= n_rem;
                r_rad[k] <= w_rad[k];
            end
        end
    end

    assign o_valid = r_valid[N-1];
    assign o_root  = r_root[N-1];
    assign o_side  = r_side[N-1];

endmodule

// ----- hw/rtl/ccc_div.sv -----
// pipelined two-lane restoring divider for the normal components
module ccc_div import ccc_pkg::*; #(
    parameter int W      = CCC_COORD_WIDTH,
    parameter int NF     = CCC_NORMAL_FRAC_BITS,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [W:0]        i_magdx,
    input  logic [W:0]        i_magdy,
    input  logic [W:0]        i_dist,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [NF:0]       o_qx,
    output logic [NF:0]       o_qy,
    output logic [SIDE_W-1:0] o_side
);

    localparam int QB = NF + 1;
    localparam int CW = W + NF + 2;

    logic [CW-1:0]     w_rem  [QB][2];
    logic [QB-1:0]     w_q    [QB][2];
    logic [W:0]        w_dist [QB];
    logic [SIDE_W-1:0] w_side [QB];
    logic              w_valid[QB];

    logic [CW-1:0]     r_rem  [QB-1][2];
    logic [W:0]        r_dist [QB-1];
    logic [QB-1:0]     r_q    [QB][2];
    logic [SIDE_W-1:0] r_side [QB];
    logic              r_valid[QB];

    // rounded numerator: |d| scaled up plus half the divisor
    logic [CW-1:0] num_x, num_y;
    assign num_x = CW'({i_magdx, {NF{1'b0}}}) + CW'(i_dist >> 1);
    assign num_y = CW'({i_magdy, {NF{1'b0}}}) + CW'(i_dist >> 1);

    for (genvar k = 0; k < QB; k++) begin : g_stage
        localparam int B = QB - 1 - k;
        logic [CW-1:0] dsh;
        logic [CW-1:0] n_rem [2];
        logic [QB-1:0] n_q   [2];

        if (k == 0) begin : g_first
            assign w_rem[k][0] = num_x;
            assign w_rem[k][1] = num_y;
            assign w_q[k][0]   = '0;
            assign w_q[k][1]   = '0;
            assign w_dist[k]   = i_dist;
            assign w_side[k]   = i_side;
            assign w_valid[k]  = i_valid;
        end else begin : g_next
            assign w_rem[k][0] = r_rem[k-1][0];
            assign w_rem[k][1] = r_rem[k-1][1];
            assign w_q[k][0]   = r_q[k-1][0];
            assign w_q[k][1]   = r_q[k-1][1];
            assign w_dist[k]   = r_dist[k-1];
            assign w_side[k]   = r_side[k-1];
            assign w_valid[k]  = r_valid[k-1];
        end

        // subtract the shifted divisor where it fits, one quotient bit per lane
        always_comb begin
            dsh = CW'(w_dist[k]) << B;
            for (int l = 0; l < 2; l++) begin
                if (w_rem[k][l] >= dsh) begin
                    n_rem[l] = w_rem[k][l] - dsh;
                    n_q[l]   = w_q[k][l] | (QB'(1) << B);
                end else begin
                    n_rem[l] = w_rem[k][l];
                    n_q[l]   = w_q[k][l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else begin
                r_valid[k] <= w_valid[k];
            end
            r_q[k][0] <= n_q[0];
            r_q[k][1] <= n_q[1];
            r_side[k] <= w_side[k];
        end

        if (k < QB - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                r_rem[k][0] <= n_rem[0];
                r_rem[k][1] <= n_rem[1];
                r_dist[k]   <= w_dist[k];
            end
        end
    end

    assign o_valid = r_valid[QB-1];
    assign o_qx    = r_q[QB-1][0];
    assign o_qy    = r_q[QB-1][1];
    assign o_side  = r_side[QB-1];

endmodule

// ----- hw/rtl/ccc_back.sv -----
// back stages: normal sign and clamp, contact point, result register
`include "assert_macros.svh"

module ccc_back import ccc_pkg::*; #(
    parameter int W  = CCC_COORD_WIDTH,
    parameter int NF = CCC_NORMAL_FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  t_flags               i_flags,
    input  logic [NF:0]          i_qx,
    input  logic [NF:0]          i_qy,
    input  logic [W:0]           i_dist,
    input  logic [W-1:0]         i_reach,
    input  logic [W-2:0]         i_r,
    input  logic [W-1:0]         i_cx,
    input  logic [W-1:0]         i_cy,
    input  logic [W-1:0]         i_px,
    input  logic [W-1:0]         i_py,
    output logic                 o_done,
    output logic                 o_hit,
    output logic [W-1:0]         o_penetration,
    output logic signed [NF+1:0] o_normal_x,
    output logic signed [NF+1:0] o_normal_y,
    output logic signed [W-1:0]  o_contact_x,
    output logic signed [W-1:0]  o_contact_y
);

    localparam logic [NF:0]       ONE   = {1'b1, {NF{1'b0}}};
    localparam logic [NF+W:0]     HALF  = (NF+W+1)'(1) << (NF - 1);
    localparam logic [W-1:0]      C_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]      C_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [NF+1:0]     N_POS = {1'b0, ONE};
    localparam logic [NF+1:0]     N_NEG = -{1'b0, ONE};

    // stage 1: clamp quotients, zero-distance case, scale by radius
    logic              r1_valid, r1_box, r1_hit, r1_negx, r1_negy;
    logic [W-1:0]      r1_pen, r1_cx, r1_cy, r1_px, r1_py;
    logic [NF+1:0]     r1_nx, r1_ny;
    logic [NF+W-1:0]   r1_prodx, r1_prody;
    logic              n1_zero, n1_negx, n1_negy;
    logic [NF:0]       n1_mx, n1_my;
    logic [NF+W-1:0]   n1_prodx, n1_prody;

    always_comb begin
        n1_zero  = (i_dist == '0);
        n1_mx    = n1_zero ? ONE : ((i_qx > ONE) ? ONE : i_qx);
        n1_my    = n1_zero ? '0  : ((i_qy > ONE) ? ONE : i_qy);
        n1_negx  = i_flags.sdx & !n1_zero;
        n1_negy  = i_flags.sdy & !n1_zero;
        n1_prodx = n1_mx * i_r;
        n1_prody = n1_my * i_r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
        end
        r1_box   <= i_flags.box;
        r1_hit   <= i_flags.hit;
        r1_negx  <= n1_negx;
        r1_negy  <= n1_negy;
        r1_pen   <= i_reach - i_dist[W-1:0];
        r1_nx    <= n1_negx ? -{1'b0, n1_mx} : {1'b0, n1_mx};
        r1_ny    <= n1_negy ? -{1'b0, n1_my} : {1'b0, n1_my};
        r1_prodx <= n1_prodx;
        r1_prody <= n1_prody;
        r1_cx    <= i_cx;
        r1_cy    <= i_cy;
        r1_px    <= i_px;
        r1_py    <= i_py;
    end

    // stage 2: round the offset, step back from the center, saturate
    logic [NF+W:0]   sum_x, sum_y;
    logic [W+1:0]    cand_x, cand_y;
    logic [W-1:0]    sat_x, sat_y;

    always_comb begin
        sum_x  = {1'b0, r1_prodx} + HALF;
        sum_y  = {1'b0, r1_prody} + HALF;
        cand_x = r1_negx ? {{2{r1_cx[W-1]}}, r1_cx} + {1'b0, sum_x[NF+W:NF]}
                         : {{2{r1_cx[W-1]}}, r1_cx} - {1'b0, sum_x[NF+W:NF]};
        cand_y = r1_negy ? {{2{r1_cy[W-1]}}, r1_cy} + {1'b0, sum_y[NF+W:NF]}
                         : {{2{r1_cy[W-1]}}, r1_cy} - {1'b0, sum_y[NF+W:NF]};
        if (cand_x[W+1:W-1] == 3'b000 || cand_x[W+1:W-1] == 3'b111) begin
            sat_x = cand_x[W-1:0];
        end else begin
            sat_x = cand_x[W+1] ? C_MIN : C_MAX;
        end
        if (cand_y[W+1:W-1] == 3'b000 || cand_y[W+1:W-1] == 3'b111) begin
            sat_y = cand_y[W-1:0];
        end else begin
            sat_y = cand_y[W+1] ? C_MIN : C_MAX;
        end
    end

    // result word: zero on a miss, but a box contact is always the clamped point
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r1_valid;
        end
        o_hit         <= r1_hit;
        o_penetration <= r1_hit ? r1_pen : '0;
        o_normal_x    <= r1_hit ? r1_nx : '0;
        o_normal_y    <= r1_hit ? r1_ny : '0;
        o_contact_x   <= r1_box ? r1_px : (r1_hit ? sat_x : '0);
        o_contact_y   <= r1_box ? r1_py : (r1_hit ? sat_y : '0);
    end

    `CCC_ASSERT(a_done_after_rst, i_clk, !i_rst_n |=> !o_done, "strobe after reset")
    `CCC_ASSERT_RST(a_latency, i_clk, i_rst_n, i_valid |-> ##2 o_done, "word lost in back end")
    `CCC_ASSERT_RST(a_miss_zero, i_clk, i_rst_n, (o_done && !o_hit) |-> (o_penetration == '0 && o_normal_x == '0 && o_normal_y == '0), "miss word not zero")
    `CCC_ASSERT_RST(a_norm_range, i_clk, i_rst_n, (o_done && o_hit) |-> ($signed(o_normal_x) <= $signed(N_POS) && $signed(o_normal_x) >= $signed(N_NEG)), "normal out of range")

endmodule

// ----- hw/rtl/circle_collision_contact.sv -----
// top level of the circle against circle or box collision pipeline
//
// One query word enters on start when busy is low; busy is always low,
// so a new query may be issued on every clock cycle.
// req_type 0 tests the circle against another circle, 1 against a box
// whose left/top corner is other_x/other_y.
// Each query gives exactly one result word, shown for one cycle with
// o_done high, in the order the queries were issued.
// The pipeline has 4 front stages, one square root stage per root bit
// (COORD_WIDTH + 1), one divider stage per quotient bit
// (NORMAL_FRAC_BITS + 1) and 2 back stages.
// Throughput is one word per cycle, set by the fully pipelined root and
// divider units.
// Synchronous active-low reset clears the valid bits; queries in flight
// are dropped and no strobe follows.
// The receiver must take every word on the cycle it is strobed.
module circle_collision_contact import ccc_pkg::*; #(
    parameter int COORD_WIDTH      = CCC_COORD_WIDTH,
    parameter int NORMAL_FRAC_BITS = CCC_NORMAL_FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_req_type,
    input  logic signed [COORD_WIDTH-1:0]      i_center_x,
    input  logic signed [COORD_WIDTH-1:0]      i_center_y,
    input  logic        [COORD_WIDTH-2:0]      i_circle_radius,
    input  logic signed [COORD_WIDTH-1:0]      i_other_x,
    input  logic signed [COORD_WIDTH-1:0]      i_other_y,
    input  logic        [COORD_WIDTH-2:0]      i_other_radius,
    input  logic        [COORD_WIDTH-2:0]      i_box_width,
    input  logic        [COORD_WIDTH-2:0]      i_box_height,
    output logic                               o_done,
    output logic                               o_hit,
    output logic        [COORD_WIDTH-1:0]      o_penetration,
    output logic signed [NORMAL_FRAC_BITS+1:0] o_normal_x,
    output logic signed [NORMAL_FRAC_BITS+1:0] o_normal_y,
    output logic signed [COORD_WIDTH-1:0]      o_contact_x,
    output logic signed [COORD_WIDTH-1:0]      o_contact_y
);

    localparam int W   = COORD_WIDTH;
    localparam int NF  = NORMAL_FRAC_BITS;
    localparam int S1W = 8 * W + 5;
    localparam int S2W = 7 * W + 4;

    // the pipeline never stalls
    assign busy = 1'b0;

    // front end
    logic           f_valid;
    t_flags         f_flags;
    logic [2*W+1:0] f_dsq;
    logic [W:0]     f_magdx, f_magdy;
    logic [W-1:0]   f_reach, f_cx, f_cy, f_px, f_py;
    logic [W-2:0]   f_r;

    ccc_front #(.W(W)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (start & ~busy),
        .i_req_type      (i_req_type),
        .i_center_x      (i_center_x),
        .i_center_y      (i_center_y),
        .i_circle_radius (i_circle_radius),
        .i_other_x       (i_other_x),
        .i_other_y       (i_other_y),
        .i_other_radius  (i_other_radius),
        .i_box_width     (i_box_width),
        .i_box_height    (i_box_height),
        .o_valid         (f_valid),
        .o_flags         (f_flags),
        .o_dsq           (f_dsq),
        .o_magdx         (f_magdx),
        .o_magdy         (f_magdy),
        .o_reach         (f_reach),
        .o_r             (f_r),
        .o_cx            (f_cx),
        .o_cy            (f_cy),
        .o_px            (f_px),
        .o_py            (f_py)
    );

    // square root of the squared distance
    logic [S1W-1:0] s_side_in, s_side_out;
    logic           s_valid;
    logic [W:0]     s_dist;
    t_flags         s_flags;
    logic [W:0]     s_magdx, s_magdy;
    logic [W-1:0]   s_reach, s_cx, s_cy, s_px, s_py;
    logic [W-2:0]   s_r;

    assign s_side_in = {f_flags, f_magdx, f_magdy, f_reach, f_r, f_cx, f_cy, f_px, f_py};

    ccc_sqrt #(.N(W + 1), .SIDE_W(S1W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_rad   (f_dsq),
        .i_side  (s_side_in),
        .o_valid (s_valid),
        .o_root  (s_dist),
        .o_side  (s_side_out)
    );

    assign {s_flags, s_magdx, s_magdy, s_reach, s_r, s_cx, s_cy, s_px, s_py} = s_side_out;

    // normal components
    logic [S2W-1:0] d_side_in, d_side_out;
    logic           d_valid;
    logic [NF:0]    d_qx, d_qy;
    t_flags         d_flags;
    logic [W:0]     d_dist;
    logic [W-1:0]   d_reach, d_cx, d_cy, d_px, d_py;
    logic [W-2:0]   d_r;

    assign d_side_in = {s_flags, s_dist, s_reach, s_r, s_cx, s_cy, s_px, s_py};

    ccc_div #(.W(W), .NF(NF), .SIDE_W(S2W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_valid),
        .i_magdx (s_magdx),
        .i_magdy (s_magdy),
        .i_dist  (s_dist),
        .i_side  (d_side_in),
        .o_valid (d_valid),
        .o_qx    (d_qx),
        .o_qy    (d_qy),
        .o_side  (d_side_out)
    );

    assign {d_flags, d_dist, d_reach, d_r, d_cx, d_cy, d_px, d_py} = d_side_out;

    // contact point and result word
    ccc_back #(.W(W), .NF(NF)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (d_valid),
        .i_flags       (d_flags),
        .i_qx          (d_qx),
        .i_qy          (d_qy),
        .i_dist        (d_dist),
        .i_reach       (d_reach),
        .i_r           (d_r),
        .i_cx          (d_cx),
        .i_cy          (d_cy),
        .i_px          (d_px),
        .i_py          (d_py),
        .o_done        (o_done),
        .o_hit         (o_hit),
        .o_penetration (o_penetration),
        .o_normal_x    (o_normal_x),
        .o_normal_y    (o_normal_y),
        .o_contact_x   (o_contact_x),
        .o_contact_y   (o_contact_y)
    );

endmodule

// ----- sim/circle_collision_contact_test.sv -----
// self-checking testbench for the circle against circle or box collision pipeline
module circle_collision_contact_test;
    import ccc_pkg::*;

    localparam int CW = CCC_COORD_WIDTH;
    localparam int NW = CCC_NORMAL_FRAC_BITS + 2;
    localparam int NFRAC = CCC_NORMAL_FRAC_BITS;
    localparam int PIPE_CYCLES = 46;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_QUERIES = 1030;
    localparam logic REQ_CIRCLE = 1'b0;
    localparam logic REQ_BOX = 1'b1;
    localparam longint COORD_HI = (64'sd1 <<< (CW - 1)) - 1;
    localparam longint COORD_LO = -(64'sd1 <<< (CW - 1));

    typedef struct {
        logic                 req_type;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic [CW-2:0]        rad;
        logic signed [CW-1:0] ox;
        logic signed [CW-1:0] oy;
        logic [CW-2:0]        orad;
        logic [CW-2:0]        bw;
        logic [CW-2:0]        bh;
    } t_query;

    typedef struct {
        logic                 hit;
        logic [CW-1:0]        pen;
        logic signed [NW-1:0] nx;
        logic signed [NW-1:0] ny;
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
    } t_contact;

    // directed row: typed expectation used where fixed is set
    typedef struct {
        t_query   q;
        logic     fixed;
        t_contact want;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_query               drv;
    logic                 o_done;
    logic                 o_hit;
    logic [CW-1:0]        o_penetration;
    logic signed [NW-1:0] o_normal_x;
    logic signed [NW-1:0] o_normal_y;
    logic signed [CW-1:0] o_contact_x;
    logic signed [CW-1:0] o_contact_y;

    t_contact pending_contacts[$];
    t_contact next_fixed;
    logic     use_fixed;
    int       mismatches;
    int       cycles;

    circle_collision_contact u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_req_type      (drv.req_type),
        .i_center_x      (drv.cx),
        .i_center_y      (drv.cy),
        .i_circle_radius (drv.rad),
        .i_other_x       (drv.ox),
        .i_other_y       (drv.oy),
        .i_other_radius  (drv.orad),
        .i_box_width     (drv.bw),
        .i_box_height    (drv.bh),
        .o_done          (o_done),
        .o_hit           (o_hit),
        .o_penetration   (o_penetration),
        .o_normal_x      (o_normal_x),
        .o_normal_y      (o_normal_y),
        .o_contact_x     (o_contact_x),
        .o_contact_y     (o_contact_y)
    );

    // clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic longint unsigned abs64(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= root + b) begin
                v = v - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    // one normal component, rounded half away from zero, clamped to one
    function automatic longint unit_comp(longint d, longint unsigned root_len);
        longint unsigned q;
        q = ((abs64(d) << NFRAC) + (root_len >> 1)) / root_len;
        if (q > (64'd1 << NFRAC)) q = 64'd1 << NFRAC;
        return d < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint sat_coord(longint v);
        if (v > COORD_HI) return COORD_HI;
        if (v < COORD_LO) return COORD_LO;
        return v;
    endfunction

    function automatic longint clamp_range(longint v, longint lo, longint hi);
        longint m;
        m = v < hi ? v : hi;
        return m > lo ? m : lo;
    endfunction

    function automatic t_contact predict_contact(t_query q);
        t_contact res;
        longint cx, cy, ox, oy, px, py, dx, dy, nx, ny, tx, ty;
        longint unsigned rad, reach, dsq, s1, root_len, pen;
        logic hit;
        cx = q.cx;
        cy = q.cy;
        ox = q.ox;
        oy = q.oy;
        rad = q.rad;
        px = 0;
        py = 0;
        nx = 0;
        ny = 0;
        pen = 0;
        if (q.req_type == REQ_BOX) begin
            px = clamp_range(cx, ox, ox + longint'(q.bw));
            py = clamp_range(cy, oy, oy + longint'(q.bh));
            dx = cx - px;
            dy = cy - py;
            reach = rad;
        end else begin
            dx = cx - ox;
            dy = cy - oy;
            reach = rad + q.orad;
        end
        s1 = abs64(dx) * abs64(dx);
        dsq = s1 + abs64(dy) * abs64(dy);
        if (dsq < s1) dsq = '1;
        hit = dsq < reach * reach;
        if (hit) begin
            root_len = int_sqrt(dsq);
            pen = reach - root_len;
            if (root_len == 0) begin
                nx = 64'sd1 <<< NFRAC;
                ny = 0;
            end else begin
                nx = unit_comp(dx, root_len);
                ny = unit_comp(dy, root_len);
            end
            if (q.req_type == REQ_CIRCLE) begin
                tx = (abs64(nx) * rad + (64'd1 << (NFRAC - 1))) >> NFRAC;
                ty = (abs64(ny) * rad + (64'd1 << (NFRAC - 1))) >> NFRAC;
                px = sat_coord(cx - (nx < 0 ? -tx : tx));
                py = sat_coord(cy - (ny < 0 ? -ty : ty));
            end
        end
        res.hit = hit;
        res.pen = pen[CW-1:0];
        res.nx = nx[NW-1:0];
        res.ny = ny[NW-1:0];
        res.px = sat_coord(px);
        res.py = sat_coord(py);
        return res;
    endfunction

    function automatic logic signed [CW-1:0] near_coord(longint base, int span);
        longint off;
        off = longint'($urandom_range(0, 2 * span)) - span;
        return sat_coord(base + off);
    endfunction

    // random query: mostly near contact at a random scale, some pure noise
    function automatic t_query random_query();
        t_query q;
        int kind;
        int scale;
        int span;
        kind = $urandom_range(0, 9);
        scale = $urandom_range(2, 22);
        span = 1 << scale;
        q.req_type = $urandom_range(0, 1);
        q.cx = $urandom;
        q.cy = $urandom;
        q.rad = $urandom;
        q.ox = $urandom;
        q.oy = $urandom;
        q.orad = $urandom;
        q.bw = $urandom;
        q.bh = $urandom;
        if (kind >= 2) begin
            if ($urandom_range(0, 3) == 0) begin
                q.cx = $urandom_range(0, 4 * span) - 2 * span;
                q.cy = $urandom_range(0, 4 * span) - 2 * span;
            end
            q.rad = $urandom_range(0, span);
            q.orad = $urandom_range(0, span);
            q.bw = $urandom_range(0, 2 * span);
            q.bh = $urandom_range(0, 2 * span);
            q.ox = near_coord(q.cx, 2 * span);
            q.oy = near_coord(q.cy, 2 * span);
            if (kind == 9) begin
                q.ox = q.cx;
                q.oy = q.cy;
            end
        end
        return q;
    endfunction

    function automatic t_query mk_query(logic rt, longint cx, longint cy, longint rad,
                                        longint ox, longint oy, longint orad,
                                        longint bw, longint bh);
        t_query q;
        q.req_type = rt;
        q.cx = cx;
        q.cy = cy;
        q.rad = rad;
        q.ox = ox;
        q.oy = oy;
        q.orad = orad;
        q.bw = bw;
        q.bh = bh;
        return q;
    endfunction

    function automatic t_contact mk_contact(logic hit, longint pen, longint nx, longint ny,
                                            longint px, longint py);
        t_contact c;
        c.hit = hit;
        c.pen = pen;
        c.nx = nx;
        c.ny = ny;
        c.px = px;
        c.py = py;
        return c;
    endfunction

    // issue one word, optionally idling first
    task automatic issue_query(t_query q, logic may_idle, logic fixed, t_contact want);
        while (may_idle && $urandom_range(0, 99) < 23) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        drv = q;
        use_fixed = fixed;
        next_fixed = want;
        start = 1'b1;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    // accept words and check results at the rising edge
    always @(posedge i_clk) begin
        t_contact want;
        if (i_rst_n) begin
            if (start && !busy) begin
                pending_contacts.push_back(use_fixed ? next_fixed : predict_contact(drv));
            end
            if (o_done) begin
                if (pending_contacts.size() == 0) begin
                    $error("result word with nothing expected");
                    mismatches++;
                end else begin
                    want = pending_contacts.pop_front();
                    if (o_hit !== want.hit) begin
                        $error("hit expected %0d got %0d", want.hit, o_hit);
                        mismatches++;
                    end
                    if (o_penetration !== want.pen) begin
                        $error("penetration expected %0d got %0d", want.pen, o_penetration);
                        mismatches++;
                    end
                    if (o_normal_x !== want.nx) begin
                        $error("normal_x expected %0d got %0d", want.nx, o_normal_x);
                        mismatches++;
                    end
                    if (o_normal_y !== want.ny) begin
                        $error("normal_y expected %0d got %0d", want.ny, o_normal_y);
                        mismatches++;
                    end
                    if (o_contact_x !== want.px) begin
                        $error("contact_x expected %0d got %0d", want.px, o_contact_x);
                        mismatches++;
                    end
                    if (o_contact_y !== want.py) begin
                        $error("contact_y expected %0d got %0d", want.py, o_contact_y);
                        mismatches++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // stimulus
    initial begin
        t_row rows[$];
        t_row row;
        t_contact none;
        none = mk_contact(0, 0, 0, 0, 0, 0);
        mismatches = 0;
        cycles = 0;
        start = 1'b0;
        use_fixed = 1'b0;
        next_fixed = none;
        drv = mk_query(REQ_CIRCLE, 0, 0, 0, 0, 0, 0, 0, 0);
        i_rst_n = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // circle miss is all zero
        rows.push_back('{mk_query(REQ_CIRCLE, 0, 0, 256, 2560, 0, 256, 0, 0), 1, none});
        // exact touch is not a hit
        rows.push_back('{mk_query(REQ_CIRCLE, 0, 0, 256, 512, 0, 256, 0, 0), 1, none});
        // zero distance gives normal along x
        rows.push_back('{mk_query(REQ_CIRCLE, 1000, -500, 256, 1000, -500, 256, 0, 0), 1,
                         mk_contact(1, 512, 16384, 0, 744, -500)});
        // center inside the box
        rows.push_back('{mk_query(REQ_BOX, 100, 100, 50, 0, 0, 0, 1000, 1000), 1,
                         mk_contact(1, 50, 16384, 0, 100, 100)});
        // box miss still reports the closest point
        rows.push_back('{mk_query(REQ_BOX, -1000, 0, 10, 0, 0, 0, 100, 100), 1,
                         mk_contact(0, 0, 0, 0, 0, 0)});
        // widest spread with largest radii
        rows.push_back('{mk_query(REQ_CIRCLE, COORD_HI, 0, COORD_HI, COORD_LO, 0, COORD_HI,
                                  0, 0), 1, none});
        // largest radii over coincident extreme centers
        rows.push_back('{mk_query(REQ_CIRCLE, COORD_LO, COORD_HI, COORD_HI, COORD_LO, COORD_HI,
                                  COORD_HI, COORD_HI, COORD_HI), 0, none});
        // contact pushed past the positive edge saturates
        rows.push_back('{mk_query(REQ_CIRCLE, 8388000, 8388000, COORD_HI, 8388600, 8388600,
                                  10, 0, 0), 0, none});
        // contact near the negative edge, pushed inward by the largest radius
        rows.push_back('{mk_query(REQ_CIRCLE, COORD_LO + 5, COORD_LO, COORD_HI, COORD_LO + 900,
                                  COORD_LO + 30, 0, 0, 0), 0, none});
        // diagonal hit with both normal signs
        rows.push_back('{mk_query(REQ_CIRCLE, 300, -300, 400, 0, 0, 100, COORD_HI, 0), 0, none});
        rows.push_back('{mk_query(REQ_CIRCLE, -300, 300, 400, 0, 0, 100, 0, COORD_HI), 0, none});
        // box edges running past the coordinate range
        rows.push_back('{mk_query(REQ_BOX, COORD_HI, COORD_HI, 5000, COORD_HI - 100,
                                  COORD_HI - 100, COORD_HI, COORD_HI, COORD_HI), 0, none});
        rows.push_back('{mk_query(REQ_BOX, COORD_LO, COORD_LO, COORD_HI, COORD_HI, COORD_HI,
                                  0, COORD_HI, COORD_HI), 0, none});
        // box hits from the left, right and bottom sides and a corner
        rows.push_back('{mk_query(REQ_BOX, -40, 500, 100, 0, 0, 0, 1000, 1000), 0, none});
        rows.push_back('{mk_query(REQ_BOX, 1040, 500, 100, 0, 0, 0, 1000, 1000), 0, none});
        rows.push_back('{mk_query(REQ_BOX, 500, 1030, 100, 0, 0, 0, 1000, 1000), 0, none});
        rows.push_back('{mk_query(REQ_BOX, -30, -40, 100, 0, 0, 0, 1000, 1000), 0, none});
        // degenerate box and zero radii
        rows.push_back('{mk_query(REQ_BOX, 10, 10, 0, 10, 10, 0, 0, 0), 0, none});
        rows.push_back('{mk_query(REQ_CIRCLE, 0, 0, 0, 0, 0, 0, 0, 0), 0, none});
        rows.push_back('{mk_query(REQ_BOX, 7, 3, 1, 0, 0, COORD_HI, 0, 0), 0, none});

        foreach (rows[i]) begin
            row = rows[i];
            issue_query(row.q, 1'b1, row.fixed, row.want);
        end

        for (int n = 0; n < RANDOM_QUERIES; n++) begin
            // hold off until the pipeline drains once
            if (n == 600) begin
                start = 1'b0;
                while (pending_contacts.size() != 0) @(negedge i_clk);
            end
            // back to back stretch with no idling
            issue_query(random_query(), !(n >= 200 && n < 450), 1'b0, none);
        end
        start = 1'b0;

        while (pending_contacts.size() != 0) @(negedge i_clk);
        repeat (PIPE_CYCLES + 10) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- circle_collision_contact.f -----
+incdir+hw/rtl
hw/rtl/ccc_pkg.sv
hw/rtl/ccc_front.sv
hw/rtl/ccc_sqrt.sv
hw/rtl/ccc_div.sv
hw/rtl/ccc_back.sv
hw/rtl/circle_collision_contact.sv
sim/circle_collision_contact_test.sv
